### rtl/dcd_pkg.sv
`default_nettype none
package dcd_pkg;

   // Field widths fixed by the transaction format
   localparam int NODE_W = 9;
   localparam int COUNT_W = 9;

   localparam int DEF_MAX_NODES = 256;
   localparam int DEF_MAX_EDGES = 1024;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_FLUSH,
      ST_INIT,
      ST_POP,
      ST_FETCH,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### rtl/dcd_req_if.sv
`default_nettype none
interface dcd_req_if;
   import dcd_pkg::*;

   logic              valid;
   logic              ready;
   logic              edge_present;
   logic [NODE_W-1:0] source_node;
   logic [NODE_W-1:0] target_node;
   logic              last_edge;

   modport source (output valid, edge_present, source_node, target_node, last_edge,
                   input ready);
   modport sink (input valid, edge_present, source_node, target_node, last_edge,
                 output ready);
endinterface
`default_nettype wire

### rtl/dcd_rsp_if.sv
`default_nettype none
interface dcd_rsp_if;
   import dcd_pkg::*;

   logic               valid;
   logic               ready;
   logic               has_cycle;
   logic [COUNT_W-1:0] ordered_nodes;
   logic               bad_input;

   modport source (output valid, has_cycle, ordered_nodes, bad_input, input ready);
   modport sink (input valid, has_cycle, ordered_nodes, bad_input, output ready);
endinterface
`default_nettype wire

### rtl/dcd_ram.sv
`default_nettype none
module dcd_ram #(
   parameter int DEPTH = 256,
   parameter int W     = 8,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [W-1:0]  wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [W-1:0]       rd_data
);
   logic [W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

### rtl/dcd_degree_ram.sv
`default_nettype none
// In-degree store. Read data is valid the cycle after the read and already
// includes a write issued in the same cycle as that read.
module dcd_degree_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   output logic [DW-1:0]      rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_q_ff;
   logic [AW-1:0] rd_addr_ff;
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic [DW-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff    <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
      end
   end

   assign rd_data = (fwd_valid_ff && fwd_addr_ff == rd_addr_ff) ? fwd_data_ff : rd_q_ff;
endmodule
`default_nettype wire

### rtl/directed_cycle_detect_kahn_unit.sv
`default_nettype none
// Directed cycle check by Kahn's topological pass.
// req_chan carries up to one edge per transaction (1-based node numbers);
// the transaction with last_edge set closes the graph and starts the check.
// rsp_chan returns one transaction per graph: has_cycle, ordered_nodes, bad_input.
// csr_wr_en/csr_wr_data write node_count; the user must do so only while the
// unit is idle, which the block itself does not enforce. Loading: one edge per
// cycle while in ST_LOAD; the in-degree read-modify-write is forwarded so
// back-to-back edges to the same target are counted correctly. After the closing
// transaction come a flush, an in-degree scan over the nodes, then for each node
// popped from the ready queue a pop, a fetch and a read of every stored edge via
// the match and update registers; at an empty queue the result is registered.
// After each result, and after reset, the in-degree store is swept to zero, one
// entry per cycle over all MAX_NODES entries; req_chan.ready is low meanwhile.
// A stalled receiver holds the result in the output register; a following graph
// may load, and its finished check waits until the previous result is taken.
// Reset is synchronous, active high; node_count returns to 1.
module directed_cycle_detect_kahn_unit #(
   parameter int MAX_NODES = dcd_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = dcd_pkg::DEF_MAX_EDGES
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [dcd_pkg::NODE_W-1:0] csr_wr_data,
   dcd_req_if.sink                        req_chan,
   dcd_rsp_if.source                      rsp_chan
);
   import dcd_pkg::*;

   localparam int NW   = $clog2(MAX_NODES);
   localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int NCW  = $clog2(MAX_NODES + 1);
   localparam int EDW  = $clog2(MAX_EDGES + 1);
   localparam int DW   = EDW;
   localparam int CMPW = (NCW > NODE_W) ? NCW : NODE_W;

   state_type state_ff, state_in;

   logic [NODE_W-1:0] node_count_ff;
   logic [CMPW-1:0]   n_cmp;
   logic [NCW-1:0]    n_nodes;

   // load side
   logic            accept, store, drop;
   logic [CMPW-1:0] src_x, dst_x;
   logic [NW-1:0]   src_idx, dst_idx;
   logic [EDW-1:0]  stored_ff;
   logic            dropped_ff;
   logic            ld_valid_ff;
   logic [NW-1:0]   ld_addr_ff;

   // pass counters
   logic [NW-1:0]   clr_ff;
   logic [NCW-1:0]  init_ff;
   logic            iv_ff;
   logic [NW-1:0]   iaddr_ff;
   logic [NCW-1:0]  head_ff, tail_ff, removed_ff;
   logic [NW-1:0]   node_ff;
   logic [EDW-1:0]  eidx_ff;
   logic            b_valid_ff, c_valid_ff;
   logic [NW-1:0]   c_addr_ff;

   // memory ports
   logic            deg_rd_en, deg_wr_en;
   logic [NW-1:0]   deg_rd_addr, deg_wr_addr;
   logic [DW-1:0]   deg_wr_data, deg_q;
   logic            edge_rd_en;
   logic [2*NW-1:0] edge_q;
   logic [NW-1:0]   e_src, e_tgt;
   logic            q_wr_en, q_rd_en;
   logic [NW-1:0]   q_wr_data, q_q;

   // control decodes
   logic init_issue, init_done, scan_issue, scan_done, b_match, deg_zero, deg_one;
   logic rsp_free, pop_any;

   // output register
   logic               rsp_valid_ff;
   logic               has_cycle_ff;
   logic [COUNT_W-1:0] ordered_ff;
   logic               bad_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_W'(1);
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // values above MAX_NODES count as MAX_NODES
   assign n_cmp   = (CMPW'(node_count_ff) > CMPW'(MAX_NODES)) ? CMPW'(MAX_NODES)
                                                             : CMPW'(node_count_ff);
   assign n_nodes = NCW'(n_cmp);

   // ---------------- edge intake ----------------
   assign accept  = req_chan.valid && req_chan.ready;
   assign src_x   = CMPW'(req_chan.source_node);
   assign dst_x   = CMPW'(req_chan.target_node);
   assign src_idx = NW'(src_x - CMPW'(1));
   assign dst_idx = NW'(dst_x - CMPW'(1));
   assign store   = accept && req_chan.edge_present
                    && src_x != '0 && src_x <= n_cmp && dst_x != '0 && dst_x <= n_cmp
                    && stored_ff < EDW'(MAX_EDGES);
   assign drop    = accept && req_chan.edge_present && !store;

   // ---------------- pass decodes ----------------
   assign b_match    = b_valid_ff && e_src == node_ff;
   assign deg_zero   = deg_q == '0;
   assign deg_one    = deg_q == DW'(1);
   assign init_issue = state_ff == ST_INIT && init_ff < n_nodes;
   assign init_done  = !init_issue && !iv_ff;
   assign scan_issue = state_ff == ST_SCAN && eidx_ff < stored_ff;
   assign scan_done  = !scan_issue && !b_valid_ff && !c_valid_ff;
   assign pop_any    = head_ff != tail_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == NW'(MAX_NODES - 1)) state_in = ST_LOAD;
         ST_LOAD:  if (accept && req_chan.last_edge) state_in = ST_FLUSH;
         ST_FLUSH: state_in = ST_INIT;
         ST_INIT:  if (init_done) state_in = ST_POP;
         ST_POP:   state_in = pop_any ? ST_FETCH : ST_DONE;
         ST_FETCH: state_in = ST_SCAN;
         ST_SCAN:  if (scan_done) state_in = ST_POP;
         ST_DONE:  if (rsp_free) state_in = ST_CLEAR;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // ---------------- outputs / memory controls ----------------
   always_comb begin
      req_chan.ready = state_ff == ST_LOAD;
      q_rd_en        = state_ff == ST_POP && pop_any;
      edge_rd_en     = scan_issue;

      deg_rd_en   = 1'b0;
      deg_rd_addr = dst_idx;
      case (state_ff)
         ST_LOAD: begin
            deg_rd_en   = store;
            deg_rd_addr = dst_idx;
         end
         ST_INIT: begin
            deg_rd_en   = init_issue;
            deg_rd_addr = NW'(init_ff);
         end
         ST_SCAN: begin
            deg_rd_en   = b_match;
            deg_rd_addr = e_tgt;
         end
         default: ;
      endcase

      // writes: clear sweep, load increment, scan decrement (exclusive in time)
      deg_wr_en   = 1'b0;
      deg_wr_addr = clr_ff;
      deg_wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         deg_wr_en = 1'b1;
      end else if (ld_valid_ff) begin
         deg_wr_en   = 1'b1;
         deg_wr_addr = ld_addr_ff;
         deg_wr_data = deg_q + DW'(1);
      end else if (c_valid_ff && !deg_zero) begin
         deg_wr_en   = 1'b1;
         deg_wr_addr = c_addr_ff;
         deg_wr_data = deg_q - DW'(1);
      end

      // ready queue push: zero in-degree at init, or released during scan
      q_wr_en   = 1'b0;
      q_wr_data = iaddr_ff;
      if (iv_ff && deg_zero) begin
         q_wr_en = 1'b1;
      end else if (c_valid_ff && deg_one && NCW'(c_addr_ff) < n_nodes) begin
         q_wr_en   = 1'b1;
         q_wr_data = c_addr_ff;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         stored_ff    <= '0;
         dropped_ff   <= 1'b0;
         ld_valid_ff  <= 1'b0;
         init_ff      <= '0;
         iv_ff        <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         removed_ff   <= '0;
         eidx_ff      <= '0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ld_valid_ff <= store;
         iv_ff       <= init_issue;
         b_valid_ff  <= scan_issue;
         c_valid_ff  <= b_match;

         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + NW'(1);
         if (store) stored_ff <= stored_ff + EDW'(1);
         if (drop) dropped_ff <= 1'b1;
         if (init_issue) init_ff <= init_ff + NCW'(1);
         if (q_wr_en) tail_ff <= tail_ff + NCW'(1);
         if (scan_issue) eidx_ff <= eidx_ff + EDW'(1);

         if (state_ff == ST_FLUSH) begin
            init_ff    <= '0;
            head_ff    <= '0;
            tail_ff    <= '0;
            removed_ff <= '0;
         end
         if (q_rd_en) begin
            head_ff    <= head_ff + NCW'(1);
            removed_ff <= removed_ff + NCW'(1);
         end
         if (state_ff == ST_FETCH) eidx_ff <= '0;

         if (rsp_valid_ff && rsp_chan.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            stored_ff    <= '0;
            dropped_ff   <= 1'b0;
            clr_ff       <= '0;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      ld_addr_ff <= dst_idx;
      iaddr_ff   <= NW'(init_ff);
      c_addr_ff  <= e_tgt;
      if (state_ff == ST_FETCH) node_ff <= q_q;
      if (state_ff == ST_DONE && rsp_free) begin
         has_cycle_ff <= CMPW'(removed_ff) < n_cmp;
         ordered_ff   <= COUNT_W'(removed_ff);
         bad_ff       <= dropped_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.has_cycle     = has_cycle_ff;
   assign rsp_chan.ordered_nodes = ordered_ff;
   assign rsp_chan.bad_input     = bad_ff;

   // ---------------- memories ----------------
   assign e_src = edge_q[2*NW-1:NW];
   assign e_tgt = edge_q[NW-1:0];

   dcd_ram #(.DEPTH(MAX_EDGES), .W(2 * NW), .AW(EW)) u_edge_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (EW'(stored_ff)),
      .wr_data ({src_idx, dst_idx}),
      .rd_en   (edge_rd_en),
      .rd_addr (EW'(eidx_ff)),
      .rd_data (edge_q)
   );

   dcd_ram #(.DEPTH(MAX_NODES), .W(NW), .AW(NW)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (NW'(tail_ff)),
      .wr_data (q_wr_data),
      .rd_en   (q_rd_en),
      .rd_addr (NW'(head_ff)),
      .rd_data (q_q)
   );

   dcd_degree_ram #(.DEPTH(MAX_NODES), .AW(NW), .DW(DW)) u_degree_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (deg_rd_en),
      .rd_addr (deg_rd_addr),
      .wr_en   (deg_wr_en),
      .wr_addr (deg_wr_addr),
      .wr_data (deg_wr_data),
      .rd_data (deg_q)
   );
endmodule
`default_nettype wire

### sim/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dcd_pkg::*;

   localparam int NODES_CAP = DEF_MAX_NODES;
   localparam int EDGES_CAP = DEF_MAX_EDGES;
   // clear sweep after reset / after each result, plus margin
   localparam int SETTLE_CYCLES = NODES_CAP + 64;
   localparam int HOLD_CYCLES = 3000;

   typedef struct {
      bit             edge_present;
      bit [NODE_W-1:0] source_node;
      bit [NODE_W-1:0] target_node;
      bit             last_edge;
   } edge_item_type;

   typedef struct {
      bit              has_cycle;
      bit [COUNT_W-1:0] ordered_nodes;
      bit              bad_input;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [NODE_W-1:0] csr_wr_data = '0;

   dcd_req_if req_bus ();
   dcd_rsp_if rsp_bus ();

   directed_cycle_detect_kahn_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow of the block: graph under construction and node count
   // ---------------------------------------------------------------
   bit [NODE_W-1:0] node_count_shadow = 9'd1;
   int unsigned edge_from [EDGES_CAP];
   int unsigned edge_to [EDGES_CAP];
   int unsigned in_deg [NODES_CAP];
   int unsigned edges_held = 0;
   bit edge_dropped = 1'b0;

   edge_item_type pending_edges[$];   // stimulus not yet offered
   verdict_type verdicts_due[$];      // predicted results, oldest first

   int unsigned fail_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   bit offering = 1'b0;

   // Kahn's pass on the shadow graph; returns the number of nodes ordered.
   function automatic int unsigned kahn_ordered_count(int unsigned n);
      int unsigned order_q [NODES_CAP];
      int unsigned head, tail, removed, node, t;
      head = 0;
      tail = 0;
      removed = 0;
      for (int i = 0; i < n; i++)
         if (in_deg[i] == 0 && tail < NODES_CAP) begin
            order_q[tail] = i;
            tail++;
         end
      while (head < tail) begin
         node = order_q[head];
         head++;
         removed++;
         for (int e = 0; e < edges_held; e++) begin
            if (edge_from[e] != node) continue;
            t = edge_to[e];
            if (t >= NODES_CAP || in_deg[t] == 0) continue;
            in_deg[t]--;
            // targets at or above the current count are never released
            if (in_deg[t] == 0 && t < n && tail < NODES_CAP) begin
               order_q[tail] = t;
               tail++;
            end
         end
      end
      return removed;
   endfunction

   // Applies one accepted transaction to the shadow; queues a verdict on last_edge.
   function automatic void absorb_edge(edge_item_type it);
      int unsigned n;
      int unsigned removed;
      verdict_type v;
      n = (node_count_shadow > NODES_CAP) ? NODES_CAP : node_count_shadow;
      if (it.edge_present) begin
         if (it.source_node >= 1 && it.source_node <= n && it.target_node >= 1 &&
             it.target_node <= n && edges_held < EDGES_CAP) begin
            edge_from[edges_held] = it.source_node - 1;
            edge_to[edges_held] = it.target_node - 1;
            edges_held++;
            in_deg[it.target_node - 1]++;
         end else begin
            edge_dropped = 1'b1;
         end
      end
      if (!it.last_edge) return;
      removed = kahn_ordered_count(n);
      v.has_cycle = (removed < n);
      v.ordered_nodes = removed[COUNT_W-1:0];
      v.bad_input = edge_dropped;
      verdicts_due.insert(verdicts_due.size(), v);
      // new graph starts with the next transaction
      foreach (in_deg[i]) in_deg[i] = 0;
      edges_held = 0;
      edge_dropped = 1'b0;
   endfunction

   // ---------------------------------------------------------------
   // Driver: offers at the falling edge, sees acceptance at the rising edge
   // ---------------------------------------------------------------
   edge_item_type on_bus;

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         absorb_edge(on_bus);
         offering = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!offering) begin
         if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            on_bus = pending_edges.pop_front();
            offering = 1'b1;
            req_bus.valid <= 1'b1;
            req_bus.edge_present <= on_bus.edge_present;
            req_bus.source_node <= on_bus.source_node;
            req_bus.target_node <= on_bus.target_node;
            req_bus.last_edge <= on_bus.last_edge;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.edge_present = 1'b0;
      req_bus.source_node = '0;
      req_bus.target_node = '0;
      req_bus.last_edge = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   // ---------------------------------------------------------------
   // Receiver: random stalls plus a long hold-off counted here
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
      end
   end

   always @(negedge clock) begin
      if (reset || hold_left > 0)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: each result transaction against the oldest verdict
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (verdicts_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("ERROR: unexpected result cycle=%0d ordered=%0d bad=%0d",
                        rsp_bus.has_cycle, rsp_bus.ordered_nodes, rsp_bus.bad_input);
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_bus.has_cycle !== want.has_cycle ||
                rsp_bus.ordered_nodes !== want.ordered_nodes ||
                rsp_bus.bad_input !== want.bad_input) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: cycle %0d/%0d ordered %0d/%0d bad %0d/%0d (exp/got)",
                           want.has_cycle, rsp_bus.has_cycle, want.ordered_nodes,
                           rsp_bus.ordered_nodes, want.bad_input, rsp_bus.bad_input);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic void push_edge(bit present, int unsigned src, int unsigned dst,
                                     bit last);
      edge_item_type it;
      it.edge_present = present;
      it.source_node = src[NODE_W-1:0];
      it.target_node = dst[NODE_W-1:0];
      it.last_edge = last;
      pending_edges.insert(pending_edges.size(), it);
   endfunction

   // Random graph: mostly forward edges (acyclic), some back edges and self
   // loops to close cycles, a few out-of-range nodes.
   function automatic void push_random_graph(int unsigned n, int unsigned max_edges);
      int unsigned cnt, a, b, roll, lim;
      lim = (n > NODES_CAP) ? NODES_CAP : ((n == 0) ? 1 : n);
      cnt = $urandom_range(max_edges);
      for (int i = 0; i < cnt; i++) begin
         a = $urandom_range(lim, 1);
         b = $urandom_range(lim, 1);
         roll = $urandom_range(99);
         if (roll < 5) begin
            // out of range: node 0 or above the node limit
            if ($urandom_range(1)) a = $urandom_range(511, lim + 1);
            else b = 0;
         end else if (roll < 80) begin
            if (a > b) begin
               int unsigned t;
               t = a;
               a = b;
               b = t;
            end
            if (a == b && b < lim) b++;
            else if (a == b && a > 1) a--;
         end
         push_edge(1'b1, a, b, (i == cnt - 1) && ($urandom_range(1) == 1));
      end
      if (pending_edges.size() == 0 || !pending_edges[$].last_edge)
         push_edge(bit'($urandom_range(1)), $urandom_range(511), $urandom_range(511),
                   1'b1);
   endfunction

   task automatic write_node_count(int unsigned value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[NODE_W-1:0];
      node_count_shadow = value[NODE_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // All stimulus taken, every verdict back, then let the clear sweep finish.
   task automatic drain();
      while (pending_edges.size() > 0 || offering || verdicts_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(int unsigned n, int unsigned items, int unsigned max_edges);
      write_node_count(n);
      while (pending_edges.size() < items) push_random_graph(n, max_edges);
      drain();
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      // directed: default count of one, self loop is a cycle
      push_edge(1'b1, 1, 1, 1'b1);
      // closing transaction with no edge on a one-node graph
      push_edge(1'b0, 511, 0, 1'b1);
      drain();

      // count above the node capacity acts as full capacity
      write_node_count(511);
      push_edge(1'b1, 1, 256, 1'b0);
      push_edge(1'b1, 256, 1, 1'b0);
      push_edge(1'b1, 257, 3, 1'b0);     // source out of range
      push_edge(1'b1, 3, 0, 1'b0);       // node zero
      push_edge(1'b0, 0, 0, 1'b1);
      push_edge(1'b1, 255, 256, 1'b1);   // edge on the last transaction
      drain();

      // zero count: empty graph, every edge dropped
      write_node_count(0);
      push_edge(1'b1, 1, 1, 1'b0);
      push_edge(1'b0, 0, 0, 1'b1);
      drain();

      // table full: extra edges beyond capacity are dropped
      write_node_count(2);
      for (int i = 0; i < EDGES_CAP + 2; i++) push_edge(1'b1, 1, 2, 1'b0);
      push_edge(1'b0, 0, 0, 1'b1);
      drain();

      // count changed mid-load: load on eight nodes, close on four
      write_node_count(8);
      push_edge(1'b1, 1, 2, 1'b0);
      push_edge(1'b1, 7, 8, 1'b0);
      push_edge(1'b1, 6, 3, 1'b0);
      push_edge(1'b1, 2, 4, 1'b0);
      drain();
      write_node_count(4);
      push_edge(1'b0, 0, 0, 1'b1);
      drain();

      // random phases across the idling modes and several counts
      send_idle_pct = 0;  recv_stall_pct = 0;
      random_phase(5, 50, 12);
      random_phase(256, 50, 24);
      send_idle_pct = 67; recv_stall_pct = 0;
      random_phase(1, 50, 6);
      random_phase(16, 50, 30);
      send_idle_pct = 0;  recv_stall_pct = 67;
      random_phase(511, 50, 20);
      random_phase(3, 50, 8);
      send_idle_pct = 37; recv_stall_pct = 37;
      random_phase(40, 50, 40);
      random_phase(0, 30, 5);

      // pressure: receiver holds off while many small graphs are offered
      send_idle_pct = 0;  recv_stall_pct = 0;
      write_node_count(4);
      hold_asked++;
      repeat (40) push_random_graph(4, 4);
      drain();

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire
